// ===== hw/rtl/delta_wake_queue_macros.svh =====
// Assertion macros for the delta wake queue.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DELTA_WAKE_QUEUE_MACROS_SVH
`define DELTA_WAKE_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define DWQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DWQ_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DWQ_ASSERT(label, clk, rst, prop, msg)
`define DWQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/dwq_pkg.sv =====
// Shared types and constants for the delta wake queue.
// No dependencies.
package dwq_pkg;
   localparam int MAX_EVENTS_DEF = 16;
   localparam int TASK_BITS_DEF = 8;
   localparam logic [19:0] US_PER_TICK_RST = 20'd10000;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_SCHED = 2'd1,
      CMD_CANCEL = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // Per-cycle command from the sequencer to every cell.
   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic load_new;
      logic sub_head;
      logic add_delta;
      logic sub_delta;
   } cell_ctl_type;
endpackage

// ===== hw/rtl/dwq_cell.sv =====
// One entry of the delta list: delta, id and task, with its neighbor links.
// Depends on dwq_pkg.
module dwq_cell #(
   parameter int TASK_BITS = dwq_pkg::TASK_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 sel,
   input  logic                 op_up,
   input  logic                 op_down,
   input  logic                 op_load,
   input  logic                 op_add,
   input  logic                 op_sub,
   input  logic [31:0]          opnd,
   input  logic [31:0]          new_delta,
   input  logic [31:0]          new_uid,
   input  logic [TASK_BITS-1:0] new_task,
   input  logic [31:0]          prev_delta,
   input  logic [31:0]          prev_uid,
   input  logic [TASK_BITS-1:0] prev_task,
   input  logic [31:0]          next_delta,
   input  logic [31:0]          next_uid,
   input  logic [TASK_BITS-1:0] next_task,
   output logic [31:0]          delta,
   output logic [31:0]          uid,
   output logic [TASK_BITS-1:0] task_no
);
   logic [31:0] delta_ff, delta_in, uid_ff, uid_in;
   logic [TASK_BITS-1:0] task_ff, task_in;

   always_comb begin
      delta_in = delta_ff;
      uid_in = uid_ff;
      task_in = task_ff;
      if (sel && op_load) begin
         delta_in = new_delta;
         uid_in = new_uid;
         task_in = new_task;
      end else if (sel && op_up) begin
         delta_in = prev_delta;
         uid_in = prev_uid;
         task_in = prev_task;
      end else if (sel && op_down) begin
         delta_in = next_delta;
         uid_in = next_uid;
         task_in = next_task;
      end else if (sel && op_add) begin
         delta_in = delta_ff + opnd;
      end else if (sel && op_sub) begin
         delta_in = delta_ff - opnd;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      uid_ff <= uid_in;
      task_ff <= task_in;
   end

   assign delta = delta_ff;
   assign uid = uid_ff;
   assign task_no = task_ff;
endmodule

// ===== hw/rtl/delta_wake_queue.sv =====
// Top level of the delta wake queue: sequencer and a row of list cells.
// Depends on dwq_pkg, dwq_cell and delta_wake_queue_macros.svh.
//
//   channel  | dir | payload
//   req_     | in  | tdata: cmd, delay_us, task_id, cancel_uid
//   rsp_     | out | tdata: kind, uid, accepted, woke, task, elapsed, ticks
//   csr_     | in  | wdata: us_per_tick
//
// Each word is accepted in the idle state and answered from the response state.
// A tick that pops the head then shifts the remaining entries toward the head.
// Schedule and cancel walk one cell per cycle, then shift one cell per cycle;
// the single walk pointer steps both the walk and the shift.
// Reset is synchronous and leaves the list empty; cells are not cleared.
// One word is in flight at a time; a stalled response holds the block.
`include "delta_wake_queue_macros.svh"
module delta_wake_queue #(
   parameter int MAX_EVENTS = dwq_pkg::MAX_EVENTS_DEF,
   parameter int TASK_BITS = dwq_pkg::TASK_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], delay_us[33:2], task_id[TB+33:34], cancel_uid above, zero pad
   input  logic [((TASK_BITS+66+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // kind[1:0], event_uid[33:2], accepted[34], woke[35], woken_task,
   // elapsed_us, tick_total, zero pad
   output logic [((TASK_BITS+100+7)/8)*8-1:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_wdata
);
   localparam int PB = $clog2(MAX_EVENTS);
   localparam int CB = $clog2(MAX_EVENTS + 1);

   dwq_pkg::state_type state_ff, state_in;
   logic [1:0] cmd_ff;
   logic [31:0] delay_ff, cuid_ff, run_ff, run_in;
   logic [TASK_BITS-1:0] task_ff;
   logic [CB-1:0] count_ff, count_in, pos_ff, pos_in, ptr_ff, ptr_in;
   logic [31:0] nuid_ff, nuid_in, sys_ff, sys_in, ticks_ff, ticks_in;
   logic [19:0] upt_ff;
   logic acc_ff, acc_in, woke_ff, woke_in, insert_in, sum_hi_ff, sum_hi_in;
   logic [TASK_BITS-1:0] wtask_ff, wtask_in;
   logic [31:0] ruid_ff, ruid_in;

   logic [31:0] d [MAX_EVENTS];
   logic [31:0] u [MAX_EVENTS];
   logic [TASK_BITS-1:0] t [MAX_EVENTS];
   logic [MAX_EVENTS-1:0] sel_v;
   dwq_pkg::cell_ctl_type ctl;
   logic [31:0] opnd, new_delta;
   logic [PB-1:0] ptr_ix;
   logic [32:0] walk_sum;
   logic [31:0] cur_d;

   assign ptr_ix = ptr_ff[PB-1:0];
   assign cur_d = d[ptr_ix];
   assign walk_sum = {sum_hi_ff, run_ff} + {1'b0, cur_d};
   assign req_tready = (state_ff == dwq_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = (state_ff == dwq_pkg::ST_RESP);
   assign new_delta = delay_ff - run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upt_ff <= dwq_pkg::US_PER_TICK_RST;
      end else if (csr_valid) begin
         upt_ff <= csr_wdata;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = dwq_pkg::ST_WALK;
            end
         end
         dwq_pkg::ST_WALK: begin
            if (insert_in || cmd_ff == dwq_pkg::CMD_NONE) begin
               state_in = (insert_in && ptr_in < count_in) ? dwq_pkg::ST_SHIFT
                                                           : dwq_pkg::ST_RESP;
               if (insert_in && acc_in && cmd_ff == dwq_pkg::CMD_SCHED) begin
                  state_in = dwq_pkg::ST_SHIFT;
               end
            end
         end
         dwq_pkg::ST_SHIFT: begin
            if (ptr_ff == pos_ff && cmd_ff == dwq_pkg::CMD_SCHED) begin
               state_in = dwq_pkg::ST_RESP;
            end else if (cmd_ff != dwq_pkg::CMD_SCHED && ptr_in >= count_ff) begin
               state_in = dwq_pkg::ST_RESP;
            end
         end
         dwq_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = dwq_pkg::ST_IDLE;
            end
         end
         default: state_in = dwq_pkg::ST_IDLE;
      endcase
   end

   // insert_in marks "walk finished"; in SHIFT, schedule shifts up from
   // count down to pos then loads, remove shifts down from pos up to count.
   always_comb begin
      ctl = '0;
      sel_v = '0;
      opnd = '0;
      run_in = run_ff;
      sum_hi_in = sum_hi_ff;
      ptr_in = ptr_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      nuid_in = nuid_ff;
      sys_in = sys_ff;
      ticks_in = ticks_ff;
      acc_in = acc_ff;
      woke_in = woke_ff;
      wtask_in = wtask_ff;
      ruid_in = ruid_ff;
      insert_in = 1'b0;
      case (state_ff)
         dwq_pkg::ST_IDLE: begin
            run_in = '0;
            sum_hi_in = 1'b0;
            ptr_in = '0;
            acc_in = 1'b0;
            woke_in = 1'b0;
            wtask_in = '0;
            ruid_in = '0;
         end
         dwq_pkg::ST_WALK: begin
            case (dwq_pkg::cmd_type'(cmd_ff))
               dwq_pkg::CMD_TICK: begin
                  insert_in = 1'b1;
                  ticks_in = ticks_ff + 32'd1;
                  sys_in = sys_ff + {12'd0, upt_ff};
                  pos_in = '0;
                  ptr_in = '0;
                  if (count_ff != '0) begin
                     if (d[0] > {12'd0, upt_ff}) begin
                        sel_v[0] = 1'b1;
                        ctl.sub_delta = 1'b1;
                        opnd = {12'd0, upt_ff};
                        ptr_in = count_ff;
                     end else begin
                        woke_in = 1'b1;
                        wtask_in = t[0];
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     ptr_in = count_ff;
                  end
               end
               dwq_pkg::CMD_SCHED: begin
                  if (count_ff >= CB'(MAX_EVENTS)) begin
                     insert_in = 1'b1;
                     ptr_in = count_ff;
                  end else if (ptr_ff >= count_ff || {1'b0, delay_ff} < walk_sum) begin
                     insert_in = 1'b1;
                     pos_in = ptr_ff;
                     ptr_in = count_ff;
                     acc_in = 1'b1;
                     ruid_in = nuid_ff;
                     nuid_in = (nuid_ff == 32'hFFFF_FFFF) ? 32'd1 : nuid_ff + 32'd1;
                     if (ptr_ff < count_ff) begin
                        sel_v[ptr_ix] = 1'b1;
                        ctl.sub_delta = 1'b1;
                        opnd = new_delta;
                     end
                  end else begin
                     {sum_hi_in, run_in} = walk_sum;
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
               dwq_pkg::CMD_CANCEL: begin
                  if (ptr_ff >= count_ff || cuid_ff == '0) begin
                     insert_in = 1'b1;
                     ptr_in = count_ff;
                  end else if (u[ptr_ix] == cuid_ff) begin
                     insert_in = 1'b1;
                     acc_in = 1'b1;
                     pos_in = ptr_ff;
                     count_in = count_ff - 1'b1;
                     if (ptr_ff + 1'b1 < count_ff) begin
                        sel_v[PB'(ptr_ff + 1'b1)] = 1'b1;
                        ctl.add_delta = 1'b1;
                        opnd = cur_d;
                     end
                  end else begin
                     ptr_in = ptr_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         dwq_pkg::ST_SHIFT: begin
            if (cmd_ff == dwq_pkg::CMD_SCHED) begin
               if (ptr_ff == pos_ff) begin
                  sel_v[ptr_ix] = 1'b1;
                  ctl.load_new = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  sel_v[ptr_ix] = 1'b1;
                  ctl.shift_up = 1'b1;
                  ptr_in = ptr_ff - 1'b1;
               end
            end else begin
               if (ptr_ff < count_ff) begin
                  sel_v[ptr_ix] = 1'b1;
                  ctl.shift_down = 1'b1;
               end
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwq_pkg::ST_IDLE;
         count_ff <= '0;
         nuid_ff <= 32'd1;
         sys_ff <= '0;
         ticks_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         nuid_ff <= nuid_in;
         sys_ff <= sys_in;
         ticks_ff <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      sum_hi_ff <= sum_hi_in;
      pos_ff <= pos_in;
      acc_ff <= acc_in;
      woke_ff <= woke_in;
      wtask_ff <= wtask_in;
      ruid_ff <= ruid_in;
      if (state_ff == dwq_pkg::ST_WALK && insert_in
          && cmd_ff != dwq_pkg::CMD_SCHED) begin
         ptr_ff <= (cmd_ff == dwq_pkg::CMD_CANCEL && acc_in) ? ptr_ff : ptr_in;
      end else begin
         ptr_ff <= ptr_in;
      end
      if (state_ff == dwq_pkg::ST_IDLE && req_tvalid) begin
         cmd_ff <= req_tdata[1:0];
         delay_ff <= req_tdata[33:2];
         task_ff <= req_tdata[TASK_BITS+33:34];
         cuid_ff <= req_tdata[TASK_BITS+65:TASK_BITS+34];
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
         localparam int PI = (gi == 0) ? 0 : gi - 1;
         localparam int NI = (gi == MAX_EVENTS - 1) ? gi : gi + 1;
         dwq_cell #(.TASK_BITS(TASK_BITS)) u_cell (
            .clock     (clock),
            .sel       (sel_v[gi]),
            .op_up     (ctl.shift_up),
            .op_down   (ctl.shift_down),
            .op_load   (ctl.load_new),
            .op_add    (ctl.add_delta),
            .op_sub    (ctl.sub_delta | ctl.sub_head),
            .opnd      (opnd),
            .new_delta (new_delta),
            .new_uid   (ruid_ff),
            .new_task  (task_ff),
            .prev_delta(d[PI]),
            .prev_uid  (u[PI]),
            .prev_task (t[PI]),
            .next_delta(d[NI]),
            .next_uid  (u[NI]),
            .next_task (t[NI]),
            .delta     (d[gi]),
            .uid       (u[gi]),
            .task_no   (t[gi])
         );
      end
   endgenerate

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[1:0] = cmd_ff;
      rsp_tdata[33:2] = ruid_ff;
      rsp_tdata[34] = acc_ff;
      rsp_tdata[35] = woke_ff;
      rsp_tdata[TASK_BITS+35:36] = wtask_ff;
      rsp_tdata[TASK_BITS+67:TASK_BITS+36] = sys_ff;
      rsp_tdata[TASK_BITS+99:TASK_BITS+68] = ticks_ff;
   end

   `DWQ_ASSERT(a_count_range, clock, reset, count_ff <= CB'(MAX_EVENTS), "entry count overflow")
   `DWQ_ASSERT(a_uid_nonzero, clock, reset, nuid_ff != '0, "next id is zero")
   `DWQ_ASSERT(a_one_hot_sel, clock, reset, $onehot0(sel_v), "more than one cell selected")
   `DWQ_ASSERT(a_woke_tick, clock, reset,
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[1:0] == dwq_pkg::CMD_TICK, "wake on non-tick")
endmodule

// ===== dv/delta_wake_queue_test.sv =====
// Self-checking testbench for the delta wake queue: a queue-fed driver, a response monitor
// and a behavioral model of the delta-ordered event list.
// Depends on dwq_pkg and the delta_wake_queue RTL.
`timescale 1ns / 1ps
module delta_wake_queue_test;
   localparam int DEPTH = dwq_pkg::MAX_EVENTS_DEF;
   localparam int REQ_W = ((dwq_pkg::TASK_BITS_DEF + 66 + 7) / 8) * 8;
   localparam int RSP_W = ((dwq_pkg::TASK_BITS_DEF + 100 + 7) / 8) * 8;
   localparam int QUIET_LIMIT = 20000;
   localparam int SLOTS = 2048;

   typedef struct packed {
      logic [31:0] cancel_uid;
      logic [7:0] task_id;
      logic [31:0] delay_us;
      dwq_pkg::cmd_type cmd;
   } wake_req_type;

   typedef struct packed {
      logic [31:0] tick_total;
      logic [31:0] elapsed_us;
      logic [7:0] woken_task;
      logic woke;
      logic accepted;
      logic [31:0] event_uid;
      dwq_pkg::cmd_type kind;
   } wake_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [19:0] csr_wdata = '0;

   delta_wake_queue dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state of the event list.
   logic [31:0] list_delta [DEPTH];
   logic [31:0] list_uid [DEPTH];
   logic [7:0] list_task [DEPTH];
   int list_len = 0;
   logic [31:0] uid_next = 32'd1;
   logic [31:0] clock_us = '0;
   logic [31:0] ticks_seen = '0;
   logic [19:0] tick_us = dwq_pkg::US_PER_TICK_RST;
   logic [31:0] uid_log [SLOTS];
   int uid_cnt = 0;

   wake_req_type pend_mem [SLOTS];
   int pend_wr = 0;
   int pend_rd = 0;
   wake_rsp_type exp_mem [SLOTS];
   int exp_wr = 0;
   int exp_rd = 0;
   int errors = 0;
   int words_sent = 0;
   int rsps_seen = 0;
   int wakes_seen = 0;
   int fulls_seen = 0;
   bit tx_free_run = 1'b0;
   bit rx_free_run = 1'b0;
   bit rx_hold = 1'b0;
   int quiet_cycles = 0;

   function automatic void remove_at(int pos);
      for (int i = pos; i + 1 < list_len; i++) begin
         list_delta[i] = list_delta[i+1];
         list_uid[i] = list_uid[i+1];
         list_task[i] = list_task[i+1];
      end
      list_len--;
   endfunction

   function automatic wake_rsp_type predict_wake(wake_req_type w);
      wake_rsp_type r;
      logic [32:0] run;
      logic [31:0] nd;
      int pos;
      r = '0;
      r.kind = w.cmd;
      case (w.cmd)
         dwq_pkg::CMD_TICK: begin
            ticks_seen++;
            clock_us += 32'(tick_us);
            if (list_len > 0) begin
               if (list_delta[0] > 32'(tick_us)) begin
                  list_delta[0] -= 32'(tick_us);
               end else begin
                  r.woke = 1'b1;
                  r.woken_task = list_task[0];
                  remove_at(0);
               end
            end
         end
         dwq_pkg::CMD_SCHED: begin
            if (list_len < DEPTH) begin
               run = '0;
               pos = 0;
               while (pos < list_len && !({1'b0, w.delay_us} < run + list_delta[pos])) begin
                  run += list_delta[pos];
                  pos++;
               end
               nd = 32'({1'b0, w.delay_us} - run);
               if (pos < list_len) list_delta[pos] -= nd;
               for (int i = list_len; i > pos; i--) begin
                  list_delta[i] = list_delta[i-1];
                  list_uid[i] = list_uid[i-1];
                  list_task[i] = list_task[i-1];
               end
               list_delta[pos] = nd;
               list_uid[pos] = uid_next;
               list_task[pos] = w.task_id;
               list_len++;
               r.event_uid = uid_next;
               r.accepted = 1'b1;
               if (uid_cnt < SLOTS) begin
                  uid_log[uid_cnt] = uid_next;
                  uid_cnt++;
               end
               uid_next++;
               if (uid_next == 0) uid_next = 32'd1;
            end
         end
         dwq_pkg::CMD_CANCEL: begin
            if (w.cancel_uid != 0) begin
               for (int i = 0; i < list_len; i++) begin
                  if (list_uid[i] == w.cancel_uid) begin
                     if (i + 1 < list_len) list_delta[i+1] += list_delta[i];
                     remove_at(i);
                     r.accepted = 1'b1;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      r.elapsed_us = clock_us;
      r.tick_total = ticks_seen;
      return r;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            exp_mem[exp_wr] = predict_wake(req_tdata[$bits(wake_req_type)-1:0]);
            exp_wr++;
            words_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pend_wr > pend_rd && (tx_free_run || $urandom_range(99) >= 35)) begin
               req_tdata <= REQ_W'(pend_mem[pend_rd]);
               pend_rd++;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      wake_rsp_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(wake_rsp_type)-1:0];
            rsps_seen++;
            if (got.woke) wakes_seen++;
            if (exp_wr == exp_rd) begin
               $display("%0t: unexpected response %h", $time, got);
               errors++;
            end else begin
               want = exp_mem[exp_rd];
               exp_rd++;
               if (got.kind == dwq_pkg::CMD_SCHED && !got.accepted) fulls_seen++;
               if (got.kind !== want.kind || got.event_uid !== want.event_uid
                   || got.accepted !== want.accepted || got.woke !== want.woke
                   || got.woken_task !== want.woken_task
                   || got.elapsed_us !== want.elapsed_us
                   || got.tick_total !== want.tick_total) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
         rsp_tready <= !rx_hold && (rx_free_run || $urandom_range(99) >= 35);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic wake_req_type make_word(dwq_pkg::cmd_type c, logic [31:0] d,
                                              logic [7:0] t, logic [31:0] u);
      wake_req_type w;
      w.cmd = c;
      w.delay_us = d;
      w.task_id = t;
      w.cancel_uid = u;
      return w;
   endfunction

   function automatic void add_word(wake_req_type w);
      pend_mem[pend_wr] = w;
      pend_wr++;
   endfunction

   function automatic logic [31:0] pick_delay();
      case ($urandom_range(5))
         0: return 32'($urandom_range(40000));
         1: return 32'($urandom_range(200000));
         2: return $urandom;
         3: return 32'hFFFF_FFFF - 32'($urandom_range(3));
         default: return 32'($urandom_range(5) * 10000);
      endcase
   endfunction

   function automatic logic [31:0] pick_uid();
      if (uid_cnt > 0 && $urandom_range(9) < 7)
         return uid_log[$urandom_range(uid_cnt - 1)];
      return $urandom_range(1) ? $urandom : 32'($urandom_range(3));
   endfunction

   task automatic queue_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 40)
            add_word(make_word(dwq_pkg::CMD_SCHED, pick_delay(), 8'($urandom), $urandom));
         else if (k < 75)
            add_word(make_word(dwq_pkg::CMD_TICK, $urandom, 8'($urandom), $urandom));
         else if (k < 95)
            add_word(make_word(dwq_pkg::CMD_CANCEL, $urandom, 8'($urandom), pick_uid()));
         else
            add_word(make_word(dwq_pkg::CMD_NONE, $urandom, 8'($urandom), $urandom));
      end
   endtask

   task automatic drain();
      while (pend_wr > pend_rd || req_tvalid || exp_wr > exp_rd)
         @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_tick_us(logic [19:0] v);
      csr_wdata <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tick_us = v;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every command, full list, unknown and zero ids.
      add_word(make_word(dwq_pkg::CMD_TICK, '0, '0, '0));
      add_word(make_word(dwq_pkg::CMD_CANCEL, '0, '0, '0));
      add_word(make_word(dwq_pkg::CMD_CANCEL, '1, '1, 32'd7));
      add_word(make_word(dwq_pkg::CMD_NONE, '1, '1, '1));
      add_word(make_word(dwq_pkg::CMD_SCHED, '1, 8'hFF, '1));
      add_word(make_word(dwq_pkg::CMD_SCHED, 32'd0, 8'h00, '0));
      for (int i = 0; i < 15; i++)
         add_word(make_word(dwq_pkg::CMD_SCHED, 32'd20000, 8'(i + 1), '0));
      add_word(make_word(dwq_pkg::CMD_CANCEL, '0, '0, 32'd1));
      add_word(make_word(dwq_pkg::CMD_CANCEL, '0, '0, 32'd3));
      add_word(make_word(dwq_pkg::CMD_TICK, '0, '0, '0));
      add_word(make_word(dwq_pkg::CMD_TICK, '0, '0, '0));
      drain();

      // The receiver holds off long enough for the block to stall its input.
      queue_random(40);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
      drain();

      write_tick_us(20'd0);
      queue_random(80);
      drain();

      write_tick_us(20'hFFFFF);
      queue_random(80);
      drain();

      write_tick_us(20'd1);
      tx_free_run = 1'b1;
      rx_free_run = 1'b1;
      queue_random(100);
      drain();
      tx_free_run = 1'b0;
      rx_free_run = 1'b0;

      write_tick_us(20'($urandom_range(1, 50000)));
      queue_random(180);
      drain();

      $display("Covered %0d words, %0d responses, %0d wakes, %0d full-list rejects.",
               words_sent, rsps_seen, wakes_seen, fulls_seen);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dwq_pkg.sv
hw/rtl/dwq_cell.sv
hw/rtl/delta_wake_queue.sv
dv/delta_wake_queue_test.sv
